// ===== design/skf_pkg.sv =====
package skf_pkg;

  // Field and state widths.
  localparam int SampleW = 16;
  localparam int GainW   = 16;
  localparam int NoiseW  = 24;
  localparam int CovW    = 26;
  localparam int DenW    = CovW + 1;
  localparam int EstW    = 32;

  // Shared multiplier operand and product widths.
  localparam int MulAW = 18;
  localparam int MulBW = 28;
  localparam int MulPW = MulAW + MulBW;

  // Register indexes on the configuration port.
  localparam logic REG_PROCESS_NOISE = 1'b0;
  localparam logic REG_MEASURE_NOISE = 1'b1;

  // Register reset values, unsigned Q16.8.
  localparam logic [NoiseW-1:0] ProcessNoiseReset = 24'd5120;
  localparam logic [NoiseW-1:0] MeasureNoiseReset = 24'd51200;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_MLO,
    ST_MHI,
    ST_UPD,
    ST_COV
  } skf_state_t;

  // Multiplier operand selection.
  typedef enum logic [1:0] {
    MSEL_GAIN_LO,
    MSEL_GAIN_HI,
    MSEL_COV
  } skf_msel_t;

endpackage

// ===== design/skf_mul.sv =====
// Shared signed multiplier with a registered product.
module skf_mul (
  input  logic                               clk,
  input  logic signed [skf_pkg::MulAW-1:0]   a,
  input  logic signed [skf_pkg::MulBW-1:0]   b,
  output logic signed [skf_pkg::MulPW-1:0]   p
);

  // One multiply per cycle; the product is ready in the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== design/scalar_kalman_filter_unit.sv =====
// One-dimensional Kalman filter (A = 1, H = 1). A sample word is accepted only
// while the block is idle. Its result word is then formed in order: the covariance
// is predicted and the divisor formed, a restoring divider yields one gain bit per
// cycle, and a single shared 18 x 28 multiplier forms the two halves of the
// estimate correction and the covariance update. The block returns to idle as the
// result word becomes valid, and can then accept the next sample. When the
// divisor is zero, or the measurement noise is zero, the gain is known at once
// and the divider takes no steps. A finished result is held in an output
// register, so the next sample may be accepted while it waits. If the word before
// is still waiting, the sequencer holds in its last cycle.
// Configuration writes must only be made while the block is idle.
module scalar_kalman_filter_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [skf_pkg::NoiseW-1:0]        cfg_data,
  // Sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [skf_pkg::SampleW-1:0] sample,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [skf_pkg::SampleW-1:0] estimate,
  output logic [skf_pkg::GainW-1:0]         gain
);

  localparam int CntW = $clog2(skf_pkg::GainW);

  // Configuration and filter state.
  logic [skf_pkg::NoiseW-1:0]       process_noise;
  logic [skf_pkg::NoiseW-1:0]       measure_noise;
  logic signed [skf_pkg::EstW-1:0]  state_estimate;
  logic [skf_pkg::CovW-1:0]         error_covariance;

  // Working registers.
  skf_pkg::skf_state_t              state, state_next;
  logic signed [skf_pkg::SampleW-1:0] sample_reg;
  logic [skf_pkg::CovW-1:0]         pmid;
  logic [skf_pkg::DenW-1:0]         den;
  logic [skf_pkg::DenW-1:0]         rem;
  logic [skf_pkg::GainW-1:0]        k;
  logic [CntW-1:0]                  cnt;
  logic                             gain_known;
  logic [15:0]                      lo_hi;

  // Shared multiplier.
  skf_pkg::skf_msel_t               msel;
  logic signed [skf_pkg::MulAW-1:0] mul_a;
  logic signed [skf_pkg::MulBW-1:0] mul_b;
  logic signed [skf_pkg::MulPW-1:0] prod;

  // Combinational helpers.
  logic [skf_pkg::CovW:0]           pmid_sum;
  logic [skf_pkg::CovW-1:0]         pmid_sat;
  logic [skf_pkg::DenW-1:0]         den_sum;
  logic [skf_pkg::DenW:0]           rem_shift;
  logic                             rem_ge;
  logic signed [32:0]               diff;
  logic signed [34:0]               nx_wide;
  logic signed [skf_pkg::EstW-1:0]  nx_sat;
  logic [skf_pkg::DenW-1:0]         pnew_wide;
  logic [skf_pkg::CovW-1:0]         pnew_sat;
  logic signed [16:0]               round_wide;
  logic signed [skf_pkg::SampleW-1:0] round_sat;
  logic                             out_free;
  logic                             finish;

  // Covariance prediction and gain divisor.
  always_comb begin
    pmid_sum = {1'b0, error_covariance} + {3'b0, process_noise};
    pmid_sat = pmid_sum[skf_pkg::CovW] ? {skf_pkg::CovW{1'b1}} : pmid_sum[skf_pkg::CovW-1:0];
    den_sum  = {1'b0, pmid_sat} + {3'b0, measure_noise};
  end

  // One restoring divider step.
  always_comb begin
    rem_shift = {rem, 1'b0};
    rem_ge    = rem_shift >= {1'b0, den};
  end

  // Innovation in Q17.16, split into a signed high half and an unsigned low half.
  assign diff = {sample_reg[skf_pkg::SampleW-1], sample_reg, 16'b0}
              - {state_estimate[skf_pkg::EstW-1], state_estimate};

  // Operand selection for the shared multiplier.
  always_comb begin
    case (msel)
      skf_pkg::MSEL_GAIN_LO: begin
        mul_a = {2'b0, k};
        mul_b = {12'b0, diff[15:0]};
      end
      skf_pkg::MSEL_GAIN_HI: begin
        mul_a = {2'b0, k};
        mul_b = {{11{diff[32]}}, diff[32:16]};
      end
      skf_pkg::MSEL_COV: begin
        mul_a = {1'b0, 17'(17'h10000 - {1'b0, k})};
        mul_b = {2'b0, pmid};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  skf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // New estimate: x + k*dh + floor(k*dl / 2^16), saturated to 32 bits.
  always_comb begin
    nx_wide = {{3{state_estimate[skf_pkg::EstW-1]}}, state_estimate}
            + {prod[33], prod[33:0]}
            + {19'b0, lo_hi};
    if (nx_wide > 35'sh0_7FFF_FFFF) begin
      nx_sat = {1'b0, {(skf_pkg::EstW-1){1'b1}}};
    end else if (nx_wide < -35'sh0_8000_0000) begin
      nx_sat = {1'b1, {(skf_pkg::EstW-1){1'b0}}};
    end else begin
      nx_sat = nx_wide[skf_pkg::EstW-1:0];
    end
  end

  // New covariance and rounded output.
  always_comb begin
    pnew_wide = prod[42:16];
    pnew_sat  = pnew_wide[skf_pkg::CovW] ? {skf_pkg::CovW{1'b1}}
                                          : pnew_wide[skf_pkg::CovW-1:0];
    round_wide = 17'((({state_estimate[skf_pkg::EstW-1], state_estimate}
                       + 33'sd32768) >>> 16));
    if (round_wide > 17'sd32767) begin
      round_sat = 16'sh7FFF;
    end else if (round_wide < -17'sd32768) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = round_wide[15:0];
    end
  end

  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      skf_pkg::ST_IDLE: if (in_valid) state_next = skf_pkg::ST_PRED;
      skf_pkg::ST_PRED: state_next = skf_pkg::ST_DIV;
      skf_pkg::ST_DIV: begin
        if (gain_known || cnt == CntW'(skf_pkg::GainW - 1)) state_next = skf_pkg::ST_MLO;
      end
      skf_pkg::ST_MLO: state_next = skf_pkg::ST_MHI;
      skf_pkg::ST_MHI: state_next = skf_pkg::ST_UPD;
      skf_pkg::ST_UPD: state_next = skf_pkg::ST_COV;
      skf_pkg::ST_COV: if (out_free) state_next = skf_pkg::ST_IDLE;
      default: state_next = skf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    msel     = skf_pkg::MSEL_GAIN_LO;
    finish   = 1'b0;
    case (state)
      skf_pkg::ST_IDLE: in_stall = 1'b0;
      skf_pkg::ST_MLO:  msel = skf_pkg::MSEL_GAIN_LO;
      skf_pkg::ST_MHI:  msel = skf_pkg::MSEL_GAIN_HI;
      skf_pkg::ST_UPD:  msel = skf_pkg::MSEL_COV;
      skf_pkg::ST_COV: begin
        msel   = skf_pkg::MSEL_COV;
        finish = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control state, configuration and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= skf_pkg::ST_IDLE;
      process_noise    <= skf_pkg::ProcessNoiseReset;
      measure_noise    <= skf_pkg::MeasureNoiseReset;
      state_estimate   <= '0;
      error_covariance <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == skf_pkg::REG_PROCESS_NOISE) begin
          process_noise <= cfg_data;
        end else begin
          measure_noise <= cfg_data;
        end
      end
      if (state == skf_pkg::ST_UPD) begin
        state_estimate <= nx_sat;
      end
      if (finish) begin
        error_covariance <= pnew_sat;
        out_valid        <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == skf_pkg::ST_IDLE && in_valid) begin
      sample_reg <= sample;
    end
    case (state)
      skf_pkg::ST_PRED: begin
        pmid <= pmid_sat;
        den  <= den_sum;
        rem  <= {1'b0, pmid_sat};
        cnt  <= '0;
        // Zero divisor gives a zero gain; zero measurement noise saturates it.
        if (den_sum == '0) begin
          gain_known <= 1'b1;
          k          <= '0;
        end else if (measure_noise == '0) begin
          gain_known <= 1'b1;
          k          <= {skf_pkg::GainW{1'b1}};
        end else begin
          gain_known <= 1'b0;
          k          <= '0;
        end
      end
      skf_pkg::ST_DIV: begin
        if (!gain_known) begin
          cnt <= cnt + 1'b1;
          k   <= {k[skf_pkg::GainW-2:0], rem_ge};
          rem <= rem_ge ? skf_pkg::DenW'(rem_shift - {1'b0, den})
                        : rem_shift[skf_pkg::DenW-1:0];
        end
      end
      skf_pkg::ST_MHI: lo_hi <= prod[31:16];
      default: begin
      end
    endcase
    if (finish) begin
      estimate <= round_sat;
      gain     <= k;
    end
  end

endmodule
